// ----- design/kclt_pkg.sv -----
package kclt_pkg;

   localparam int KEY_W  = 64;
   localparam int DATA_W = 32;
   localparam int TIME_W = 32;
   localparam int CAP_W  = 5;

   // Operation codes of an input transaction.
   localparam logic [1:0] MODE_GET        = 2'd0;
   localparam logic [1:0] MODE_PUT        = 2'd1;
   localparam logic [1:0] MODE_INVALIDATE = 2'd2;
   localparam logic [1:0] MODE_CLEAR      = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_MISS      = 2'd1;
   localparam logic [1:0] STAT_EXPIRED   = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_CAPACITY = 2'd0;
   localparam logic [1:0] REG_POLICY   = 2'd1;
   localparam logic [1:0] REG_EXPIRY   = 2'd2;
   localparam logic [1:0] REG_TTL      = 2'd3;

   localparam logic POLICY_LRU = 1'b0;
   localparam logic POLICY_LFU = 1'b1;

   typedef struct packed {
      logic [CAP_W-1:0]  capacity;
      logic              replace_policy;
      logic [1:0]        expiry_mode;
      logic [TIME_W-1:0] ttl_seconds;
   } cfg_type;

endpackage

// ----- design/kclt_ram.sv -----
module kclt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kclt_csr.sv -----
module kclt_csr
   import kclt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity       <= CAP_W'(16);
         cfg_ff.replace_policy <= POLICY_LRU;
         cfg_ff.expiry_mode    <= 2'd0;
         cfg_ff.ttl_seconds    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CAPACITY: cfg_ff.capacity       <= csr_wdata[CAP_W-1:0];
            REG_POLICY:   cfg_ff.replace_policy <= csr_wdata[0];
            REG_EXPIRY:   cfg_ff.expiry_mode    <= csr_wdata[1:0];
            REG_TTL:      cfg_ff.ttl_seconds    <= csr_wdata[TIME_W-1:0];
            default:      cfg_ff.ttl_seconds    <= cfg_ff.ttl_seconds;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/keyed_cache_lru_lfu_ttl.sv -----
// Channel        Ports                               Handshake
// request        req_mode req_key req_value req_now  accepted when start is high and busy low
// response       rsp_status rsp_hit_value            one-cycle strobe rsp_valid
//                rsp_evicted rsp_held_count
// configuration  csr_we csr_index csr_wdata          written when csr_we is high
//
// A get that misses, an invalidate of an absent key and a clear respond after the search sweep
// alone; every other transaction adds a rewrite sweep. Both sweeps pass through the single slot
// RAM: the search sweep looks for the key, the victim and the first free slot, and the rewrite
// sweep rewrites the recency ranks and the one target slot.
// Reset is synchronous and empties the cache; slot contents are not cleared since the valid
// bits guard them. The response cannot be stalled; busy falls in the cycle it is shown.
module keyed_cache_lru_lfu_ttl
   import kclt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [DATA_W-1:0] req_value,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [DATA_W-1:0] rsp_hit_value,
   output logic              rsp_evicted,
   output logic [CAP_W-1:0]  rsp_held_count,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int RW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

   // One slot as it is stored in the RAM. The rank is 0 for the most recent entry.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
      logic [TIME_W-1:0] created;
      logic [31:0]       uses;
      logic [RW-1:0]     rank;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_PASS
   } state_type;

   cfg_type cfg;

   kclt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer state.
   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [1:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // What the search sweep found.
   logic              hit_ff, hit_in;
   logic [RW-1:0]     hit_slot_ff, hit_slot_in;
   rec_type           hit_rec_ff, hit_rec_in;
   logic              vic_ff, vic_in;
   logic [RW-1:0]     vic_slot_ff, vic_slot_in;
   logic [RW-1:0]     vic_rank_ff, vic_rank_in;
   logic [31:0]       vic_uses_ff, vic_uses_in;
   logic              free_ff, free_in;
   logic [RW-1:0]     free_slot_ff, free_slot_in;

   // Occupancy.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]      total_ff, total_in;

   // How the rewrite sweep adjusts the ranks, and the one slot it rewrites in full.
   logic              drop_ff, drop_in;
   logic [RW-1:0]     drop_rank_ff, drop_rank_in;
   logic              bump_all_ff, bump_all_in;
   logic              bump_below_ff, bump_below_in;
   logic [RW-1:0]     bump_rank_ff, bump_rank_in;
   logic              tgt_ff, tgt_in;
   logic [RW-1:0]     tgt_slot_ff, tgt_slot_in;
   rec_type           tgt_rec_ff, tgt_rec_in;

   // Response registers.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_hit_value_ff, rsp_hit_value_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   logic [CAP_W-1:0]  rsp_held_ff, rsp_held_in;

   // RAM port.
   logic              ram_we;
   logic [RW-1:0]     ram_wr_addr;
   rec_type           ram_wr_rec;
   logic [RW-1:0]     ram_rd_addr;
   logic [REC_W-1:0]  ram_rd_data;
   rec_type           rd_rec;

   kclt_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_rec),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_rec = rec_type'(ram_rd_data);

   logic [CW-1:0] cnt_m1;
   logic [RW-1:0] pidx;
   logic          pvalid;
   logic [CW-1:0] cap_eff;

   // The slot whose read data arrives now is the one addressed in the cycle before.
   assign cnt_m1      = cnt_ff - 1'b1;
   assign pidx        = cnt_m1[RW-1:0];
   assign pvalid      = valid_ff[pidx];
   assign ram_rd_addr = (cnt_ff < ENT_C) ? cnt_ff[RW-1:0] : '0;

   always_comb begin
      if (cfg.capacity == '0) begin
         cap_eff = CW'(1);
      end else if (32'(cfg.capacity) > ENTRIES) begin
         cap_eff = ENT_C;
      end else begin
         cap_eff = CW'(cfg.capacity);
      end
   end

   logic          expired;
   logic [31:0]   age;
   logic          do_evict;
   logic [RW-1:0] ins_slot;
   logic [RW-1:0] new_rank;

   assign age     = now_ff - hit_rec_ff.created;
   assign expired = cfg.expiry_mode[0] && (age > cfg.ttl_seconds);
   assign do_evict = (total_ff >= cap_eff) && vic_ff;

   // After an eviction the lowest free slot is the lower of the victim and the first free one.
   always_comb begin
      if (do_evict && (!free_ff || (vic_slot_ff < free_slot_ff))) begin
         ins_slot = vic_slot_ff;
      end else begin
         ins_slot = free_slot_ff;
      end
   end

   // Rank of a surviving slot after a removal and an insertion or promotion.
   always_comb begin
      new_rank = rd_rec.rank;
      if (drop_ff && (rd_rec.rank > drop_rank_ff)) begin
         new_rank = new_rank - 1'b1;
      end
      if (bump_all_ff || (bump_below_ff && (rd_rec.rank < bump_rank_ff))) begin
         new_rank = new_rank + 1'b1;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      op_in            = op_ff;
      key_in           = key_ff;
      value_in         = value_ff;
      now_in           = now_ff;
      hit_in           = hit_ff;
      hit_slot_in      = hit_slot_ff;
      hit_rec_in       = hit_rec_ff;
      vic_in           = vic_ff;
      vic_slot_in      = vic_slot_ff;
      vic_rank_in      = vic_rank_ff;
      vic_uses_in      = vic_uses_ff;
      free_in          = free_ff;
      free_slot_in     = free_slot_ff;
      valid_in         = valid_ff;
      total_in         = total_ff;
      drop_in          = drop_ff;
      drop_rank_in     = drop_rank_ff;
      bump_all_in      = bump_all_ff;
      bump_below_in    = bump_below_ff;
      bump_rank_in     = bump_rank_ff;
      tgt_in           = tgt_ff;
      tgt_slot_in      = tgt_slot_ff;
      tgt_rec_in       = tgt_rec_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_hit_value_in = rsp_hit_value_ff;
      rsp_evicted_in   = rsp_evicted_ff;
      rsp_held_in      = rsp_held_ff;
      ram_we           = 1'b0;
      ram_wr_addr      = pidx;
      ram_wr_rec       = rd_rec;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               cnt_in   = '0;
               op_in    = req_mode;
               key_in   = req_key;
               value_in = req_value;
               now_in   = req_now;
               hit_in   = 1'b0;
               vic_in   = 1'b0;
               free_in  = 1'b0;
            end
         end

         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               if (pvalid && (rd_rec.key == key_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = pidx;
                  hit_rec_in  = rd_rec;
               end
               if (pvalid) begin
                  if (!vic_ff ||
                      ((cfg.replace_policy == POLICY_LRU) && (rd_rec.rank > vic_rank_ff)) ||
                      ((cfg.replace_policy == POLICY_LFU) && (rd_rec.uses < vic_uses_ff))) begin
                     vic_in      = 1'b1;
                     vic_slot_in = pidx;
                     vic_rank_in = rd_rec.rank;
                     vic_uses_in = rd_rec.uses;
                  end
               end else if (!free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = pidx;
               end
            end
            if (cnt_ff == ENT_C) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            drop_in          = 1'b0;
            bump_all_in      = 1'b0;
            bump_below_in    = 1'b0;
            tgt_in           = 1'b0;
            rsp_status_in    = STAT_OK;
            rsp_hit_value_in = '0;
            rsp_evicted_in   = 1'b0;
            state_in         = S_PASS;
            cnt_in           = '0;
            tgt_rec_in       = hit_rec_ff;
            tgt_slot_in      = hit_slot_ff;
            bump_rank_in     = hit_rec_ff.rank;
            drop_rank_in     = hit_rec_ff.rank;

            unique case (op_ff)
               MODE_GET: begin
                  if (!hit_ff) begin
                     rsp_status_in = STAT_MISS;
                     state_in      = S_IDLE;
                     rsp_valid_in  = 1'b1;
                  end else if (expired) begin
                     rsp_status_in         = STAT_EXPIRED;
                     drop_in               = 1'b1;
                     valid_in[hit_slot_ff] = 1'b0;
                     total_in              = total_ff - 1'b1;
                  end else begin
                     tgt_in = 1'b1;
                     if (hit_rec_ff.uses != '1) begin
                        tgt_rec_in.uses = hit_rec_ff.uses + 1'b1;
                     end
                     if (cfg.replace_policy == POLICY_LRU) begin
                        bump_below_in   = 1'b1;
                        tgt_rec_in.rank = '0;
                     end
                     rsp_hit_value_in = hit_rec_ff.value;
                  end
               end

               MODE_PUT: begin
                  tgt_in             = 1'b1;
                  tgt_rec_in.key     = key_ff;
                  tgt_rec_in.value   = value_ff;
                  tgt_rec_in.created = now_ff;
                  tgt_rec_in.uses    = 32'd1;
                  if (hit_ff) begin
                     if (cfg.replace_policy == POLICY_LRU) begin
                        bump_below_in   = 1'b1;
                        tgt_rec_in.rank = '0;
                     end
                  end else begin
                     // A new key: free one slot if full, then enter as most recent.
                     if (do_evict) begin
                        drop_in               = 1'b1;
                        drop_rank_in          = vic_rank_ff;
                        valid_in[vic_slot_ff] = 1'b0;
                        rsp_evicted_in        = 1'b1;
                     end
                     bump_all_in        = 1'b1;
                     tgt_slot_in        = ins_slot;
                     tgt_rec_in.rank    = '0;
                     valid_in[ins_slot] = 1'b1;
                     total_in           = do_evict ? total_ff : total_ff + 1'b1;
                  end
               end

               MODE_INVALIDATE: begin
                  if (hit_ff) begin
                     drop_in               = 1'b1;
                     valid_in[hit_slot_ff] = 1'b0;
                     total_in              = total_ff - 1'b1;
                  end else begin
                     rsp_status_in = STAT_NOT_FOUND;
                     state_in      = S_IDLE;
                     rsp_valid_in  = 1'b1;
                  end
               end

               MODE_CLEAR: begin
                  valid_in     = '0;
                  total_in     = '0;
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end

               default: begin
                  state_in = S_IDLE;
               end
            endcase
            rsp_held_in = CAP_W'(total_in);
         end

         S_PASS: begin
            // Reads run one slot ahead of writes, so a write never meets a pending read.
            cnt_in = cnt_ff + 1'b1;
            if ((cnt_ff != '0) && pvalid) begin
               ram_we = 1'b1;
               if (tgt_ff && (pidx == tgt_slot_ff)) begin
                  ram_wr_rec = tgt_rec_ff;
               end else begin
                  ram_wr_rec      = rd_rec;
                  ram_wr_rec.rank = new_rank;
               end
            end
            if (cnt_ff == ENT_C) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff            <= op_in;
      key_ff           <= key_in;
      value_ff         <= value_in;
      now_ff           <= now_in;
      hit_ff           <= hit_in;
      hit_slot_ff      <= hit_slot_in;
      hit_rec_ff       <= hit_rec_in;
      vic_ff           <= vic_in;
      vic_slot_ff      <= vic_slot_in;
      vic_rank_ff      <= vic_rank_in;
      vic_uses_ff      <= vic_uses_in;
      free_ff          <= free_in;
      free_slot_ff     <= free_slot_in;
      drop_ff          <= drop_in;
      drop_rank_ff     <= drop_rank_in;
      bump_all_ff      <= bump_all_in;
      bump_below_ff    <= bump_below_in;
      bump_rank_ff     <= bump_rank_in;
      tgt_ff           <= tgt_in;
      tgt_slot_ff      <= tgt_slot_in;
      tgt_rec_ff       <= tgt_rec_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_hit_value_ff <= rsp_hit_value_in;
      rsp_evicted_ff   <= rsp_evicted_in;
      rsp_held_ff      <= rsp_held_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_hit_value  = rsp_hit_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_held_count = rsp_held_ff;

   // The entry count always agrees with the valid bits.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(total_ff))
      else $error("entry count differs from the number of valid slots");

   // A response is never shown twice in a row.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // An accepted transaction keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted without going busy");

   // Only a get hit returns a handle.
   a_hit_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_hit_value == '0))
      else $error("handle returned on a response that is not a hit");

   // An eviction is reported only with an OK status and a count that is not zero. Only an insertion evicts.
   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (rsp_status == STAT_OK && total_ff != '0))
      else $error("eviction reported on a failed transaction or an empty cache");

endmodule
